FILE: rtl/ict_pkg.sv
// shared constants, operation and status codes, and control structs
// for the interrupt controller; no dependencies
package ict_pkg;

    localparam int LINE_COUNT = 32;
    localparam int LINE_W     = $clog2(LINE_COUNT);

    localparam logic [31:0] SERVICE_FLOOR_MASK = 32'hfffffffc;
    localparam logic [31:0] ALL_LINES_MASK     = 32'hffffffff >> (32 - LINE_COUNT);
    localparam logic [31:0] MASK_ALL_ON        = 32'hffffffff;
    localparam logic [31:0] MASK_ALL_OFF       = 32'h0;

    localparam logic [3:0] OP_REGISTER    = 4'd0;
    localparam logic [3:0] OP_FREE        = 4'd1;
    localparam logic [3:0] OP_ENABLE      = 4'd2;
    localparam logic [3:0] OP_DISABLE     = 4'd3;
    localparam logic [3:0] OP_ENABLE_ALL  = 4'd4;
    localparam logic [3:0] OP_DISABLE_ALL = 4'd5;
    localparam logic [3:0] OP_RAISE       = 4'd6;
    localparam logic [3:0] OP_SERVICE     = 4'd7;
    localparam logic [3:0] OP_QUERY       = 4'd8;

    localparam logic [2:0] ST_OK              = 3'd0;
    localparam logic [2:0] ST_NO_SUCH_LINE    = 3'd1;
    localparam logic [2:0] ST_NOT_REGISTERED  = 3'd2;
    localparam logic [2:0] ST_INVALID_HANDLER = 3'd3;
    localparam logic [2:0] ST_ALREADY_REG     = 3'd4;
    localparam logic [2:0] ST_BUSY            = 3'd5;
    localparam logic [2:0] ST_NOTHING_PENDING = 3'd6;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
    } dpath_stat_t;

endpackage

FILE: rtl/ict_if.sv
// request and result channel interfaces for the interrupt controller
// no dependencies
interface ict_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [5:0]  line;
    logic [15:0] handler_id;

    modport source (output valid, operation, line, handler_id, input ready);
    modport sink (input valid, operation, line, handler_id, output ready);
endinterface

interface ict_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [4:0]  serviced_line;
    logic [15:0] serviced_handler;
    logic        handler_present;
    logic        line_enabled;
    logic        global_on;

    modport source (output valid, status, serviced_line, serviced_handler,
                    handler_present, line_enabled, global_on, input ready);
    modport sink (input valid, status, serviced_line, serviced_handler,
                  handler_present, line_enabled, global_on, output ready);
endinterface

FILE: rtl/ict_ram.sv
// generic single write port ram with registered read
// no dependencies
module ict_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/ict_ctrl.sv
// controller state machine: accepts one request, then executes it
// depends on ict_pkg
module ict_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  ict_pkg::dpath_stat_t stat,
    output ict_pkg::ctrl_cmd_t   cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready    = (state_reg == S_IDLE);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.execute = (state_reg == S_EXEC) && stat.slot_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/ict_dpath.sv
// datapath: handler table ram, mask, pending and enable registers,
// priority encoder and result register; depends on ict_pkg and ict_ram
module ict_dpath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ict_pkg::ctrl_cmd_t   cmd,
    output ict_pkg::dpath_stat_t stat,
    input  logic [3:0]           operation,
    input  logic [5:0]           line,
    input  logic [15:0]          handler_id,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output logic [2:0]           status,
    output logic [4:0]           serviced_line,
    output logic [15:0]          serviced_handler,
    output logic                 handler_present,
    output logic                 line_enabled,
    output logic                 global_on
);

    localparam int LW = ict_pkg::LINE_W;
    localparam int LC = ict_pkg::LINE_COUNT;

    logic [3:0]    op_reg;
    logic [5:0]    line_reg;
    logic [15:0]   hid_reg;
    logic [LW-1:0] addr_reg;
    logic          cand_any_reg;

    logic [LC-1:0] valid_reg;
    logic [LC-1:0] valid_next;
    logic [31:0]   mask_reg;
    logic [31:0]   mask_next;
    logic [31:0]   pend_reg;
    logic [31:0]   pend_next;
    logic          gen_reg;
    logic          gen_next;

    logic          out_valid_reg;
    logic [2:0]    status_reg;
    logic [2:0]    status_next;
    logic [4:0]    sline_reg;
    logic [4:0]    sline_next;
    logic [15:0]   shandler_reg;
    logic [15:0]   shandler_next;
    logic          present_reg;
    logic          present_next;
    logic          enabled_reg;
    logic          enabled_next;

    logic [31:0]   cand;
    logic [4:0]    low_k;
    logic [LW-1:0] in_addr;
    logic [LW-1:0] raddr;
    logic [15:0]   rdata;
    logic [15:0]   entry;
    logic          in_range;
    logic [31:0]   line_bit;
    logic [31:0]   svc_bit;
    logic          ram_we;

    // lowest pending line from 2 upward
    assign cand = pend_reg & ict_pkg::SERVICE_FLOOR_MASK & ict_pkg::ALL_LINES_MASK;

    always_comb
    begin
        low_k = '0;
        for (int i = 31; i >= 0; i--)
        begin
            if (cand[i])
            begin
                low_k = 5'(i);
            end
        end
    end

    assign in_addr = (operation == ict_pkg::OP_SERVICE) ? low_k[LW-1:0] : line[LW-1:0];
    assign raddr   = cmd.capture ? in_addr : addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= operation;
            line_reg     <= line;
            hid_reg      <= handler_id;
            addr_reg     <= in_addr;
            cand_any_reg <= (cand != 32'h0);
        end
    end

    ict_ram #(
        .WIDTH (16),
        .DEPTH (LC)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (hid_reg),
        .raddr (raddr),
        .rdata (rdata)
    );

    // unwritten entries read as no handler
    assign entry    = valid_reg[addr_reg] ? rdata : 16'h0;
    assign in_range = (line_reg < 6'(LC));
    assign line_bit = 32'd1 << line_reg[4:0];
    assign svc_bit  = 32'd1 << 5'(addr_reg);

    always_comb
    begin
        valid_next    = valid_reg;
        mask_next     = mask_reg;
        pend_next     = pend_reg;
        gen_next      = gen_reg;
        ram_we        = 1'b0;
        status_next   = ict_pkg::ST_OK;
        sline_next    = '0;
        shandler_next = '0;
        present_next  = 1'b0;
        enabled_next  = 1'b0;
        unique case (op_reg)
            ict_pkg::OP_REGISTER:
            begin
                if (!in_range)
                    status_next = ict_pkg::ST_NO_SUCH_LINE;
                else if (hid_reg == 16'h0)
                    status_next = ict_pkg::ST_INVALID_HANDLER;
                else if (entry != 16'h0)
                    status_next = ict_pkg::ST_ALREADY_REG;
                else
                begin
                    ram_we               = cmd.execute;
                    valid_next[addr_reg] = 1'b1;
                end
            end
            ict_pkg::OP_FREE:
            begin
                if (!in_range)
                    status_next = ict_pkg::ST_NO_SUCH_LINE;
                else if (line_reg > 6'd1 && (mask_reg & line_bit) != 32'h0)
                    status_next = ict_pkg::ST_BUSY;
                else
                    valid_next[addr_reg] = 1'b0;
            end
            ict_pkg::OP_ENABLE:
            begin
                if (!in_range)
                    status_next = ict_pkg::ST_NO_SUCH_LINE;
                else if (entry == 16'h0)
                    status_next = ict_pkg::ST_NOT_REGISTERED;
                else
                    mask_next = mask_reg | line_bit;
            end
            ict_pkg::OP_DISABLE:
            begin
                if (!in_range)
                    status_next = ict_pkg::ST_NO_SUCH_LINE;
                else
                    mask_next = mask_reg & ~line_bit;
            end
            ict_pkg::OP_ENABLE_ALL:
            begin
                gen_next  = 1'b1;
                mask_next = ict_pkg::MASK_ALL_ON;
            end
            ict_pkg::OP_DISABLE_ALL:
            begin
                gen_next  = 1'b0;
                mask_next = ict_pkg::MASK_ALL_OFF;
            end
            ict_pkg::OP_RAISE:
            begin
                if (!in_range)
                    status_next = ict_pkg::ST_NO_SUCH_LINE;
                else
                    pend_next = pend_reg | line_bit;
            end
            ict_pkg::OP_SERVICE:
            begin
                if (!cand_any_reg)
                    status_next = ict_pkg::ST_NOTHING_PENDING;
                else
                begin
                    pend_next     = pend_reg & ~svc_bit;
                    sline_next    = 5'(addr_reg);
                    shandler_next = entry;
                    present_next  = (entry != 16'h0);
                end
            end
            ict_pkg::OP_QUERY:
            begin
                if (!in_range)
                    status_next = ict_pkg::ST_NO_SUCH_LINE;
                else
                begin
                    present_next = (entry != 16'h0);
                    enabled_next = ((mask_reg & line_bit) != 32'h0);
                end
            end
            default:
            begin
                status_next = ict_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            mask_reg  <= '0;
            pend_reg  <= '0;
            gen_reg   <= 1'b0;
        end
        else if (cmd.execute)
        begin
            valid_reg <= valid_next;
            mask_reg  <= mask_next;
            pend_reg  <= pend_next;
            gen_reg   <= gen_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.execute)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            status_reg   <= status_next;
            sline_reg    <= sline_next;
            shandler_reg <= shandler_next;
            present_reg  <= present_next;
            enabled_reg  <= enabled_next;
        end
    end

    assign stat.slot_free = !out_valid_reg || rsp_ready;

    assign rsp_valid        = out_valid_reg;
    assign status           = status_reg;
    assign serviced_line    = sline_reg;
    assign serviced_handler = shandler_reg;
    assign handler_present  = present_reg;
    assign line_enabled     = enabled_reg;
    assign global_on        = gen_reg;

endmodule

FILE: rtl/interrupt_controller_with_handler_table.sv
// top level of the interrupt controller with handler table
// depends on ict_pkg, ict_if, ict_ctrl and ict_dpath
//
// Each request on req (register, free, enable, disable, enable all,
// disable all, raise, service, query) yields exactly one result on rsp.
// The transfer cycle of a request reads the handler table RAM (registered
// read) at the addressed line, or at the lowest pending line from 2
// upward for service; the operation then executes and loads the result
// register once the result slot is free, and req.ready returns high in
// the cycle after execution. The result register frees the request side
// from the result side, so execution stalls only while an earlier result
// is still waiting to be taken. The table needs no clearing pass:
// per-entry valid bits make it read as empty right after reset.
module interrupt_controller_with_handler_table (
    input  logic    clk,
    input  logic    rst_n,
    ict_req_if.sink req,
    ict_rsp_if.source rsp
);

    ict_pkg::ctrl_cmd_t   cmd;
    ict_pkg::dpath_stat_t stat;

    ict_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ict_dpath u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .operation        (req.operation),
        .line             (req.line),
        .handler_id       (req.handler_id),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .status           (rsp.status),
        .serviced_line    (rsp.serviced_line),
        .serviced_handler (rsp.serviced_handler),
        .handler_present  (rsp.handler_present),
        .line_enabled     (rsp.line_enabled),
        .global_on        (rsp.global_on)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request taken while another is in flight");

    a_exec_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.execute |-> !req.ready && !cmd.capture)
        else $error("execute while controller idle");

    a_service_line: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.serviced_line != 5'd0 |->
            rsp.status == ict_pkg::ST_OK && rsp.serviced_line > 5'd1
            && !rsp.line_enabled)
        else $error("serviced line below floor or bad status");

    a_handler_present: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.serviced_handler != 16'h0 |-> rsp.handler_present)
        else $error("handler reported without present flag");

endmodule

FILE: tb/interrupt_controller_with_handler_table_tb.sv
// self-checking testbench for interrupt_controller_with_handler_table
// depends on ict_pkg, ict_if and the controller rtl; predicts every result
// from its own model of the handler table, mask, pending bits and global enable
module interrupt_controller_with_handler_table_tb;

    localparam logic [3:0] OP_UNUSED_LO = 4'd9;
    localparam logic [3:0] OP_UNUSED_HI = 4'd15;
    localparam int RANDOM_ITEMS = 1950;
    localparam int HOLD_CYCLES  = 200;

    typedef struct {
        logic [3:0]  op;
        logic [5:0]  line;
        logic [15:0] hid;
    } irq_request_t;

    typedef struct {
        logic [2:0]  status;
        logic [4:0]  line;
        logic [15:0] handler;
        logic        present;
        logic        enabled;
        logic        glob;
    } irq_result_t;

    logic clk = 1'b0;
    logic rst_n;

    ict_req_if req_ch ();
    ict_rsp_if rsp_ch ();

    interrupt_controller_with_handler_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    irq_request_t request_queue[$];
    irq_result_t  expected_results[$];

    logic [15:0] vector_table [ict_pkg::LINE_COUNT];
    logic [31:0] mask_bits;
    logic [31:0] pend_bits;
    logic        global_en;

    int sent_count = 0;
    int checked_count = 0;
    int err_count = 0;
    int hold_left;
    logic hold_done;
    int status_seen [8];
    int serviced_with_handler = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #400000;
        $display("tb: failure");
        $finish;
    end

    function automatic irq_result_t predict_controller(logic [3:0] op, logic [5:0] line,
                                                       logic [15:0] hid);
        irq_result_t r;
        logic        in_range;
        logic [31:0] bit_sel;
        logic [31:0] cand;
        logic [4:0]  idx;
        logic        found;
        r = '{status: ict_pkg::ST_OK, line: '0, handler: '0, present: 1'b0,
              enabled: 1'b0, glob: 1'b0};
        in_range = line < ict_pkg::LINE_COUNT;
        bit_sel = in_range ? (32'd1 << line) : 32'd0;
        idx = line[4:0];
        found = 1'b0;
        case (op)
            ict_pkg::OP_REGISTER:
                if (!in_range) r.status = ict_pkg::ST_NO_SUCH_LINE;
                else if (hid == 16'd0) r.status = ict_pkg::ST_INVALID_HANDLER;
                else if (vector_table[idx] != 16'd0) r.status = ict_pkg::ST_ALREADY_REG;
                else vector_table[idx] = hid;
            ict_pkg::OP_FREE:
                if (!in_range) r.status = ict_pkg::ST_NO_SUCH_LINE;
                else if (line > 1 && (mask_bits & bit_sel) != 0) r.status = ict_pkg::ST_BUSY;
                else vector_table[idx] = 16'd0;
            ict_pkg::OP_ENABLE:
                if (!in_range) r.status = ict_pkg::ST_NO_SUCH_LINE;
                else if (vector_table[idx] == 16'd0) r.status = ict_pkg::ST_NOT_REGISTERED;
                else mask_bits = mask_bits | bit_sel;
            ict_pkg::OP_DISABLE:
                if (!in_range) r.status = ict_pkg::ST_NO_SUCH_LINE;
                else mask_bits = mask_bits & ~bit_sel;
            ict_pkg::OP_ENABLE_ALL:
            begin
                global_en = 1'b1;
                mask_bits = ict_pkg::MASK_ALL_ON;
            end
            ict_pkg::OP_DISABLE_ALL:
            begin
                global_en = 1'b0;
                mask_bits = ict_pkg::MASK_ALL_OFF;
            end
            ict_pkg::OP_RAISE:
                if (!in_range) r.status = ict_pkg::ST_NO_SUCH_LINE;
                else pend_bits = pend_bits | bit_sel;
            ict_pkg::OP_SERVICE:
            begin
                cand = pend_bits & ict_pkg::SERVICE_FLOOR_MASK & ict_pkg::ALL_LINES_MASK;
                if (cand == 0)
                begin
                    r.status = ict_pkg::ST_NOTHING_PENDING;
                end
                else
                begin
                    for (int k = 0; k < 32; k++)
                    begin
                        if (!found && cand[k])
                        begin
                            found = 1'b1;
                            pend_bits[k] = 1'b0;
                            r.line = k[4:0];
                            r.handler = vector_table[k];
                            r.present = vector_table[k] != 16'd0;
                        end
                    end
                end
            end
            ict_pkg::OP_QUERY:
                if (!in_range)
                begin
                    r.status = ict_pkg::ST_NO_SUCH_LINE;
                end
                else
                begin
                    r.present = vector_table[idx] != 16'd0;
                    r.enabled = (mask_bits & bit_sel) != 0;
                end
            default:
            begin
            end
        endcase
        r.glob = global_en;
        return r;
    endfunction

    function automatic irq_request_t random_request();
        irq_request_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 18) r.op = ict_pkg::OP_REGISTER;
        else if (pick < 28) r.op = ict_pkg::OP_FREE;
        else if (pick < 40) r.op = ict_pkg::OP_ENABLE;
        else if (pick < 48) r.op = ict_pkg::OP_DISABLE;
        else if (pick < 51) r.op = ict_pkg::OP_ENABLE_ALL;
        else if (pick < 54) r.op = ict_pkg::OP_DISABLE_ALL;
        else if (pick < 74) r.op = ict_pkg::OP_RAISE;
        else if (pick < 90) r.op = ict_pkg::OP_SERVICE;
        else if (pick < 97) r.op = ict_pkg::OP_QUERY;
        else r.op = 4'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        pick = $urandom_range(99);
        if (pick < 10) r.line = 6'($urandom_range(3));
        else if (pick < 85) r.line = 6'($urandom_range(ict_pkg::LINE_COUNT - 1));
        else r.line = 6'($urandom_range(63, ict_pkg::LINE_COUNT));
        pick = $urandom_range(99);
        if (pick < 6) r.hid = 16'd0;
        else if (pick < 10) r.hid = 16'hffff;
        else r.hid = 16'($urandom_range(16'hffff));
        return r;
    endfunction

    task automatic push_req(logic [3:0] op, logic [5:0] line, logic [15:0] hid);
        request_queue.push_back('{op: op, line: line, hid: hid});
    endtask

    task automatic flag_mismatch(string what, int got, int want);
        err_count++;
        $display("tb: mismatch on %s: got %0d, expected %0d at %0t", what, got, want,
                 $realtime);
    endtask

    task automatic check_result(irq_result_t want);
        if (rsp_ch.status !== want.status)
            flag_mismatch("status", rsp_ch.status, want.status);
        if (rsp_ch.serviced_line !== want.line)
            flag_mismatch("serviced_line", rsp_ch.serviced_line, want.line);
        if (rsp_ch.serviced_handler !== want.handler)
            flag_mismatch("serviced_handler", rsp_ch.serviced_handler, want.handler);
        if (rsp_ch.handler_present !== want.present)
            flag_mismatch("handler_present", rsp_ch.handler_present, want.present);
        if (rsp_ch.line_enabled !== want.enabled)
            flag_mismatch("line_enabled", rsp_ch.line_enabled, want.enabled);
        if (rsp_ch.global_on !== want.glob)
            flag_mismatch("global_on", rsp_ch.global_on, want.glob);
        status_seen[want.status]++;
        if (want.status == ict_pkg::ST_OK && want.present && want.line != 0)
            serviced_with_handler++;
    endtask

    function automatic logic calm_window();
        return sent_count >= 700 && sent_count < 1000;
    endfunction

    // long receiver hold-off so the controller backs up into its request side
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && sent_count >= 400)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.operation <= '0;
            req_ch.line <= '0;
            req_ch.handler_id <= '0;
        end
        else
        begin : drive
            irq_request_t nxt;
            if (req_ch.valid && req_ch.ready)
            begin
                expected_results.push_back(predict_controller(req_ch.operation, req_ch.line,
                                                              req_ch.handler_id));
                sent_count <= sent_count + 1;
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (request_queue.size() > 0 &&
                    (hold_left > 0 || calm_window() || $urandom_range(99) >= 27))
                begin
                    nxt = request_queue.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.operation <= nxt.op;
                    req_ch.line <= nxt.line;
                    req_ch.handler_id <= nxt.hid;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                checked_count++;
                if (expected_results.size() == 0)
                    flag_mismatch("result with no request outstanding", rsp_ch.status, -1);
                else
                    check_result(expected_results.pop_front());
            end
            rsp_ch.ready <= hold_left == 0 && (calm_window() || $urandom_range(99) >= 27);
        end
    end

    initial
    begin
        for (int i = 0; i < ict_pkg::LINE_COUNT; i++)
            vector_table[i] = 16'd0;
        mask_bits = ict_pkg::MASK_ALL_OFF;
        pend_bits = ict_pkg::MASK_ALL_OFF;
        global_en = 1'b0;
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;

        // directed corner cases
        push_req(ict_pkg::OP_QUERY, 6'd0, 16'd0);
        push_req(ict_pkg::OP_SERVICE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_REGISTER, 6'd2, 16'd0);
        push_req(ict_pkg::OP_REGISTER, 6'd63, 16'hffff);
        push_req(ict_pkg::OP_REGISTER, 6'd2, 16'hffff);
        push_req(ict_pkg::OP_REGISTER, 6'd2, 16'h1234);
        push_req(ict_pkg::OP_REGISTER, 6'd31, 16'h0001);
        push_req(ict_pkg::OP_REGISTER, 6'd0, 16'h8000);
        push_req(ict_pkg::OP_ENABLE, 6'd3, 16'd0);
        push_req(ict_pkg::OP_ENABLE, 6'd2, 16'd0);
        push_req(ict_pkg::OP_FREE, 6'd2, 16'd0);
        push_req(ict_pkg::OP_ENABLE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_FREE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_RAISE, 6'd1, 16'd0);
        push_req(ict_pkg::OP_RAISE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_RAISE, 6'd31, 16'd0);
        push_req(ict_pkg::OP_RAISE, 6'd5, 16'd0);
        push_req(ict_pkg::OP_SERVICE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_SERVICE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_SERVICE, 6'd0, 16'd0);
        push_req(ict_pkg::OP_ENABLE_ALL, 6'd0, 16'd0);
        push_req(ict_pkg::OP_FREE, 6'd31, 16'd0);
        push_req(ict_pkg::OP_QUERY, 6'd31, 16'd0);
        push_req(ict_pkg::OP_DISABLE_ALL, 6'd0, 16'd0);
        push_req(ict_pkg::OP_QUERY, 6'd40, 16'd0);
        push_req(OP_UNUSED_LO, 6'd7, 16'h5555);
        push_req(OP_UNUSED_HI, 6'd63, 16'haaaa);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            request_queue.push_back(random_request());

        @(posedge rst_n);
        while (request_queue.size() > 0 || req_ch.valid)
            @(negedge clk);
        while (expected_results.size() > 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        $display("tb: %0d requests sent, %0d results checked, %0d errors",
                 sent_count, checked_count, err_count);
        $display("tb: ok %0d, no_such_line %0d, busy %0d, nothing_pending %0d, %0d with handler",
                 status_seen[ict_pkg::ST_OK], status_seen[ict_pkg::ST_NO_SUCH_LINE],
                 status_seen[ict_pkg::ST_BUSY], status_seen[ict_pkg::ST_NOTHING_PENDING],
                 serviced_with_handler);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
